@@ rtl/core/xpf_pkg.sv @@
// Package for the XOR parity FEC encoder.
// Shared constants, stream field layout and parity chain control types.
// No dependencies.
package xpf_pkg;

    localparam int PAYLOAD_WORDS = 20;
    localparam int WORD_W        = 64;
    localparam int SEQ_W         = 32;
    localparam int POS_W         = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int GSIZE_W       = 4;
    localparam int TDATA_W       = SEQ_W + WORD_W;
    localparam int TUSER_W       = 2;

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 4'd2;

    localparam logic TYPE_DATA   = 1'b0;
    localparam logic TYPE_PARITY = 1'b1;

    localparam int TUSER_TYPE_BIT = 0;
    localparam int TUSER_RUN_BIT  = 1;

    typedef enum logic [1:0] {
        FEED_LOAD,
        FEED_XOR,
        FEED_ROTATE
    } t_feed;

    typedef struct packed {
        logic  shift;
        t_feed feed;
    } t_chain_ctl;

endpackage

@@ rtl/core/xor_parity_fec_encoder_top.sv @@
// XOR parity FEC encoder, top level: stream handshakes, framing counters, output register.
// Uses xpf_pkg and xpf_chain.
//
// Each input word is forwarded as a data word in the next cycle; input is
// accepted while the output register is empty or being read.
// The word that closes a group of frames_per_group frames is followed by a parity
// packet of PAYLOAD_WORDS words shifted out of the cell row, one per cycle while
// the output is not stalled, during which input is held off. Data and parity
// words share the single output register.
module xor_parity_fec_encoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [xpf_pkg::GSIZE_W-1:0] i_cfg_data,     // frames_per_group
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [xpf_pkg::TDATA_W-1:0] s_axis_tdata,   // seq_number, payload_word
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [xpf_pkg::TDATA_W-1:0] m_axis_tdata,   // packet_seq, out_word
    output logic                        m_axis_tlast,   // last_of_packet
    output logic [xpf_pkg::TUSER_W-1:0] m_axis_tuser    // packet_type, last_of_run
);

    typedef enum logic {
        ST_DATA,
        ST_PARITY
    } t_state;

    t_state                      r_state;
    logic [xpf_pkg::POS_W-1:0]   r_pos;
    logic [xpf_pkg::POS_W-1:0]   r_burst_cnt;
    logic [xpf_pkg::GSIZE_W-1:0] r_frames;
    logic [xpf_pkg::GSIZE_W-1:0] r_gsize;
    logic [xpf_pkg::SEQ_W-1:0]   r_group_seq;
    logic                        r_out_valid;
    logic                        r_out_type;
    logic [xpf_pkg::SEQ_W-1:0]   r_out_seq;
    logic [xpf_pkg::WORD_W-1:0]  r_out_word;
    logic                        r_out_last_pkt;
    logic                        r_out_last_run;

    logic                        w_slot_free;
    logic                        w_in_acc;
    logic                        w_par_emit;
    logic                        w_frame_end;
    logic                        w_group_end;
    logic                        w_burst_last;
    logic [xpf_pkg::SEQ_W-1:0]   w_seq;
    logic [xpf_pkg::WORD_W-1:0]  w_word;
    logic [xpf_pkg::WORD_W-1:0]  w_head;
    xpf_pkg::t_chain_ctl         w_ctl;

    assign w_seq  = s_axis_tdata[xpf_pkg::SEQ_W-1:0];
    assign w_word = s_axis_tdata[xpf_pkg::TDATA_W-1:xpf_pkg::SEQ_W];

    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_DATA) && w_slot_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_par_emit    = (r_state == ST_PARITY) && w_slot_free;

    assign w_frame_end  = (r_pos == xpf_pkg::POS_W'(xpf_pkg::PAYLOAD_WORDS - 1));
    assign w_burst_last = (r_burst_cnt == xpf_pkg::POS_W'(xpf_pkg::PAYLOAD_WORDS - 1));
    assign w_group_end  = w_frame_end &&
        (({1'b0, r_frames} + (xpf_pkg::GSIZE_W+1)'(1)) >= {1'b0, r_gsize});

    always_comb begin
        w_ctl.shift = w_in_acc || w_par_emit;
        if (w_in_acc) begin
            w_ctl.feed = (r_frames == '0) ? xpf_pkg::FEED_LOAD : xpf_pkg::FEED_XOR;
        end else begin
            w_ctl.feed = xpf_pkg::FEED_ROTATE;
        end
    end

    xpf_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_word (w_word),
        .o_head (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DATA;
            r_pos       <= '0;
            r_burst_cnt <= '0;
            r_frames    <= '0;
            r_gsize     <= xpf_pkg::GSIZE_RESET;
            r_group_seq <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gsize <= i_cfg_data;
            end
            if (w_in_acc) begin
                if (r_frames == '0 && r_pos == '0) begin
                    r_group_seq <= w_seq;
                end
                if (w_frame_end) begin
                    r_pos <= '0;
                    if (w_group_end) begin
                        r_frames    <= '0;
                        r_state     <= ST_PARITY;
                        r_burst_cnt <= '0;
                    end else begin
                        r_frames <= r_frames + xpf_pkg::GSIZE_W'(1);
                    end
                end else begin
                    r_pos <= r_pos + xpf_pkg::POS_W'(1);
                end
                r_out_valid    <= 1'b1;
                r_out_type     <= xpf_pkg::TYPE_DATA;
                r_out_seq      <= w_seq;
                r_out_word     <= w_word;
                r_out_last_pkt <= w_frame_end;
                r_out_last_run <= !w_group_end;
            end else if (w_par_emit) begin
                if (w_burst_last) begin
                    r_state <= ST_DATA;
                end
                r_burst_cnt    <= r_burst_cnt + xpf_pkg::POS_W'(1);
                r_out_valid    <= 1'b1;
                r_out_type     <= xpf_pkg::TYPE_PARITY;
                r_out_seq      <= r_group_seq;
                r_out_word     <= w_head;
                r_out_last_pkt <= w_burst_last;
                r_out_last_run <= w_burst_last;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_word, r_out_seq};
    assign m_axis_tlast  = r_out_last_pkt;
    assign m_axis_tuser  = {r_out_last_run, r_out_type};

endmodule

@@ rtl/core/xpf_cell.sv @@
// One parity store cell: holds one 64-bit running XOR entry.
// Takes its i_d value on shift (a neighbor's, or the feed at the tail). Uses xpf_pkg.
module xpf_cell (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic [xpf_pkg::WORD_W-1:0] i_d,
    output logic [xpf_pkg::WORD_W-1:0] o_q
);

    logic [xpf_pkg::WORD_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/core/xpf_chain.sv @@
// Row of xpf_cell instances forming a rotating parity store.
// Head cell holds the entry for the current word position. Uses xpf_pkg, xpf_cell.
module xpf_chain (
    input  logic                       i_clk,
    input  xpf_pkg::t_chain_ctl        i_ctl,
    input  logic [xpf_pkg::WORD_W-1:0] i_word,
    output logic [xpf_pkg::WORD_W-1:0] o_head
);

    logic [xpf_pkg::WORD_W-1:0] w_q [xpf_pkg::PAYLOAD_WORDS];
    logic [xpf_pkg::WORD_W-1:0] w_tail;

    always_comb begin
        case (i_ctl.feed)
            xpf_pkg::FEED_LOAD:   w_tail = i_word;
            xpf_pkg::FEED_XOR:    w_tail = w_q[0] ^ i_word;
            xpf_pkg::FEED_ROTATE: w_tail = w_q[0];
            default:              w_tail = w_q[0];
        endcase
    end

    for (genvar g = 0; g < xpf_pkg::PAYLOAD_WORDS; g++) begin : g_cell
        logic [xpf_pkg::WORD_W-1:0] w_d;
        if (g == xpf_pkg::PAYLOAD_WORDS - 1) begin : g_tail
            assign w_d = w_tail;
        end else begin : g_mid
            assign w_d = w_q[g+1];
        end
        xpf_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_d     (w_d),
            .o_q     (w_q[g])
        );
    end

    assign o_head = w_q[0];

endmodule

@@ rtl/core/xpf_checker.sv @@
// Port-level checker for xor_parity_fec_encoder_top, attached by bind.
// Uses xpf_pkg.
module xpf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [xpf_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast,
    input logic [xpf_pkg::TUSER_W-1:0] m_axis_tuser
);

    logic w_par;
    logic w_run;

    assign w_par = m_axis_tuser[xpf_pkg::TUSER_TYPE_BIT];
    assign w_run = m_axis_tuser[xpf_pkg::TUSER_RUN_BIT];

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // parity words end the run exactly at the packet end
    a_par_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_par |-> w_run == m_axis_tlast)
        else $error("parity last flags disagree");

    // a data word that does not end its run closes a frame
    a_data_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_par && !w_run |-> m_axis_tlast)
        else $error("group close off a frame boundary");

    // no input while the parity packet is still going out
    a_burst_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_par && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted during parity packet");

    // parity packet follows the group-closing data word
    a_par_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !w_par && !w_run |=> m_axis_tvalid && w_par)
        else $error("parity packet missing after group close");

endmodule

bind xor_parity_fec_encoder_top xpf_checker u_xpf_checker (.*);

@@ tb/sv/xor_parity_fec_encoder_top_test.sv @@
`timescale 1ns / 100ps
// Testbench for xor_parity_fec_encoder_top: a directed frame table, then random frames
// over several group sizes; every output transaction is checked against a behavioral encoder.
// Depends on xpf_pkg and the encoder RTL.
module xor_parity_fec_encoder_top_test;

    localparam int ITEM_TARGET   = 460;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIR_N         = xpf_pkg::PAYLOAD_WORDS;

    typedef struct packed {
        logic                       ptype;
        logic [xpf_pkg::SEQ_W-1:0]  pseq;
        logic [xpf_pkg::WORD_W-1:0] word;
        logic                       last_pkt;
        logic                       last_run;
    } t_fec_word;

    typedef struct packed {
        logic                       typed;
        logic [xpf_pkg::SEQ_W-1:0]  seq;
        logic [xpf_pkg::WORD_W-1:0] word;
    } t_dir_row;

    // one frame right after reset; typed rows are forwarded as-is, mid-frame, end of run
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{1'b1, 32'h0000_0000, 64'h0000_0000_0000_0000},
        '{1'b1, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b1, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000},
        '{1'b1, 32'hFFFF_FFFF, 64'h0000_0000_0000_0001},
        '{1'b1, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA},
        '{1'b1, 32'h0000_0001, 64'h5555_5555_5555_5555},
        '{1'b1, 32'h5555_5555, 64'h0123_4567_89AB_CDEF},
        '{1'b1, 32'hAAAA_AAAA, 64'hFEDC_BA98_7654_3210},
        '{1'b1, 32'h0000_0000, 64'hFF00_FF00_FF00_FF00},
        '{1'b1, 32'h0000_0000, 64'h00FF_00FF_00FF_00FF},
        '{1'b1, 32'h0000_0000, 64'hFFFF_FFFF_0000_0000},
        '{1'b1, 32'h0000_0000, 64'h0000_0000_FFFF_FFFF},
        '{1'b1, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF},
        '{1'b1, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFE},
        '{1'b1, 32'h0000_0000, 64'h0000_0000_0000_0000},
        '{1'b1, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b1, 32'h0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0},
        '{1'b1, 32'hF0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F},
        '{1'b1, 32'h0000_0000, 64'hDEAD_BEEF_CAFE_F00D},
        '{1'b0, 32'h0000_0000, 64'h1111_2222_3333_4444}
    };

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [xpf_pkg::GSIZE_W-1:0]  i_cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [xpf_pkg::TDATA_W-1:0]  s_axis_tdata;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [xpf_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                         m_axis_tlast;
    logic [xpf_pkg::TUSER_W-1:0]  m_axis_tuser;

    // encoder model state
    logic [xpf_pkg::WORD_W-1:0]   parity_acc [xpf_pkg::PAYLOAD_WORDS];
    int unsigned                  next_pos         = 0;
    logic [xpf_pkg::GSIZE_W-1:0]  frames_done      = '0;
    logic [xpf_pkg::SEQ_W-1:0]    group_seq        = '0;
    logic [xpf_pkg::GSIZE_W-1:0]  frames_per_group = xpf_pkg::GSIZE_RESET;
    t_fec_word                    pending_words [$];

    logic [xpf_pkg::SEQ_W-1:0]    frame_seq   = 32'hFFFF_FFF0;
    int                           error_count = 0;
    int                           words_sent  = 0;
    int                           idle_cycles = 0;
    bit                           send_quiet  = 1'b0;
    bit                           recv_quiet  = 1'b0;

    always #6 i_clk = ~i_clk;

    xor_parity_fec_encoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic void encode_word(logic [xpf_pkg::SEQ_W-1:0] seq,
                                        logic [xpf_pkg::WORD_W-1:0] word);
        bit frame_end;
        bit group_end;
        frame_end = (next_pos == xpf_pkg::PAYLOAD_WORDS - 1);
        group_end = 1'b0;
        if (frames_done == '0) begin
            if (next_pos == 0) begin
                group_seq = seq;
            end
            parity_acc[next_pos] = word;
        end else begin
            parity_acc[next_pos] ^= word;
        end
        if (frame_end) begin
            next_pos = 0;
            if ({1'b0, frames_done} + 5'd1 >= {1'b0, frames_per_group}) begin
                group_end   = 1'b1;
                frames_done = '0;
            end else begin
                frames_done++;
            end
        end else begin
            next_pos++;
        end
        pending_words.push_back(t_fec_word'{xpf_pkg::TYPE_DATA, seq, word, frame_end,
                                            !group_end});
        if (group_end) begin
            for (int i = 0; i < xpf_pkg::PAYLOAD_WORDS; i++) begin
                pending_words.push_back(t_fec_word'{xpf_pkg::TYPE_PARITY, group_seq,
                                                    parity_acc[i],
                                                    i == xpf_pkg::PAYLOAD_WORDS - 1,
                                                    i == xpf_pkg::PAYLOAD_WORDS - 1});
            end
        end
    endfunction

    function automatic logic [xpf_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // per-transaction wait; quiet stretches run back to back
    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 29) == 0) begin
            quiet = !quiet;
        end
        return quiet ? 0 : int'($urandom_range(0, 17));
    endfunction

    function automatic void check_field(string name, logic [xpf_pkg::WORD_W-1:0] want,
                                        logic [xpf_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_word(input logic [xpf_pkg::SEQ_W-1:0] seq,
                             input logic [xpf_pkg::WORD_W-1:0] word,
                             input bit typed);
        int gap;
        int slot;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {word, seq};
        do @(posedge i_clk); while (!s_axis_tready);
        slot = pending_words.size();
        encode_word(seq, word);
        if (typed) begin
            pending_words[slot] = t_fec_word'{xpf_pkg::TYPE_DATA, seq, word, 1'b0, 1'b1};
        end
        words_sent++;
    endtask

    task automatic send_frame();
        bit scramble;
        scramble = ($urandom_range(0, 4) == 0);
        for (int p = 0; p < xpf_pkg::PAYLOAD_WORDS; p++) begin
            send_word((scramble && $urandom_range(0, 2) == 0) ?
                      xpf_pkg::SEQ_W'($urandom) : frame_seq,
                      rand_word(), 1'b0);
        end
        frame_seq += ($urandom_range(0, 9) == 0) ? xpf_pkg::SEQ_W'($urandom)
                                                 : xpf_pkg::SEQ_W'(1);
    endtask

    // written only once the output side has drained
    task automatic set_group_size(input logic [xpf_pkg::GSIZE_W-1:0] size);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        frames_per_group = size;
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap(recv_quiet);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_fec_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected output transaction: tdata %h tuser %b", m_axis_tdata,
                       m_axis_tuser);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                check_field("packet_type", want.ptype,
                            m_axis_tuser[xpf_pkg::TUSER_TYPE_BIT]);
                check_field("packet_seq", want.pseq, m_axis_tdata[xpf_pkg::SEQ_W-1:0]);
                check_field("out_word", want.word,
                            m_axis_tdata[xpf_pkg::SEQ_W +: xpf_pkg::WORD_W]);
                check_field("last_of_packet", want.last_pkt, m_axis_tlast);
                check_field("last_of_run", want.last_run,
                            m_axis_tuser[xpf_pkg::TUSER_RUN_BIT]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("** xor_parity_fec_encoder_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            send_word(DIR_ROWS[r].seq, DIR_ROWS[r].word, DIR_ROWS[r].typed);
        end

        // size zero acts as one and closes the open group of two
        set_group_size(4'd0);
        send_frame();
        set_group_size(4'd15);
        repeat (15) send_frame();
        set_group_size(4'd5);
        repeat (2) send_frame();
        // lowered below the frames already seen
        set_group_size(4'd1);
        send_frame();

        while (words_sent < ITEM_TARGET) begin
            set_group_size(($urandom_range(0, 3) == 0) ?
                           xpf_pkg::GSIZE_W'($urandom) :
                           xpf_pkg::GSIZE_W'($urandom_range(1, 3)));
            repeat ($urandom_range(1, 3)) send_frame();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** xor_parity_fec_encoder_top: PASSED **");
        end else begin
            $display("** xor_parity_fec_encoder_top: FAILED **");
        end
        $finish;
    end

endmodule
